[sv/text_console_engine_defines.svh]
// ---------------------------------------------------------------------------
// text_console_engine_defines
// Assertion macros used by the console engine RTL.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_ENGINE_DEFINES_SVH
`ifndef SYNTH
// Condition must hold at every edge out of reset
`define TCE_ASSERT(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// Precondition implies postcondition in the next cycle
`define TCE_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define TCE_ASSERT(name, cond, msg)
`define TCE_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

[sv/tce_pkg.sv]
// ---------------------------------------------------------------------------
// tce_pkg
// Types, constants and address helpers of the text console engine.
// ---------------------------------------------------------------------------
package tce_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLS + 1);
    localparam int ROW_W  = $clog2(ROWS + 1);

    localparam logic signed [9:0] COLS_S = 10'(COLS);
    localparam logic signed [9:0] ROWS_S = 10'(ROWS);

    localparam logic [7:0]  RESET_COLOR = 8'h07;
    localparam logic [7:0]  CHAR_SPACE  = 8'h20;
    localparam logic [7:0]  CHAR_NL     = 8'h0A;
    localparam logic [7:0]  CHAR_CR     = 8'h0D;
    localparam logic [7:0]  CHAR_BS     = 8'h08;
    localparam logic [7:0]  CHAR_TAB    = 8'h09;
    localparam logic [15:0] RESET_BLANK = {RESET_COLOR, CHAR_SPACE};

    typedef enum logic [2:0] {
        OP_PUT, OP_CLEAR, OP_SET_CURSOR, OP_ERASE,
        OP_SCROLL, OP_SHIFT, OP_WRITE, OP_READ
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_COPY_RD, S_COPY_WR, S_FILL, S_POKE, S_READ, S_DONE
    } t_state;

    // Work list for one item: block copy, block fill, one cell write, one read
    typedef struct packed {
        logic              cp_en;
        logic              cp_down;
        logic [ADDR_W-1:0] cp_src;
        logic [ADDR_W-1:0] cp_dst;
        logic [CNT_W-1:0]  cp_len;
        logic              fl_en;
        logic [ADDR_W-1:0] fl_start;
        logic [CNT_W-1:0]  fl_len;
        logic [15:0]       fl_val;
        logic              pk_en;
        logic [ADDR_W-1:0] pk_addr;
        logic [15:0]       pk_val;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic [6:0]        cur_col;
        logic [4:0]        cur_row;
        logic [10:0]       hw_pos;
    } t_plan;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] hw_cursor_pos;
        logic [15:0] cell_data;
    } t_result;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [9:0] x,
                                                    input logic signed [9:0] y);
        return ADDR_W'(int'(y) * COLS + int'(x));
    endfunction

    function automatic logic [CNT_W-1:0] row_len(input logic signed [9:0] n);
        return CNT_W'(int'(n) * COLS);
    endfunction

    function automatic logic [CNT_W-1:0] cell_len(input logic signed [9:0] n);
        return CNT_W'(int'(n));
    endfunction

endpackage

[sv/text_console_engine.sv]
// ---------------------------------------------------------------------------
// text_console_engine
// Character-cell console: 80x25 screen store, cursor, scroll, shift, erase.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// command   in         push / full          op, char_code, attribute, positions, count
// result    out        empty / pop          cursor, hardware cursor address, cell data
// config    in         cfg_valid/cfg_ready  text color
//
// Scroll, shift and wrap move each cell with a read and then a write and blank
// each cell with one write, all through the single write port of the screen
// store; clear blanks all 2000 cells through the same port.
// After reset a clearing pass blanks all 2000 cells of the store; full stays high.
// Up to two decoded items queue ahead of the executor; two results can wait.
// ---------------------------------------------------------------------------
module text_console_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_op,
    input  logic [7:0]         i_char_code,
    input  logic [7:0]         i_cell_attribute,
    input  logic signed [7:0]  i_col,
    input  logic signed [7:0]  i_row,
    input  logic signed [7:0]  i_col_end,
    input  logic signed [7:0]  i_region_top,
    input  logic signed [7:0]  i_region_bottom,
    input  logic signed [7:0]  i_count,
    output logic               empty,
    input  logic               pop,
    output logic [6:0]         o_cursor_col,
    output logic [4:0]         o_cursor_row,
    output logic [10:0]        o_hw_cursor_pos,
    output logic [15:0]        o_cell_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);

    tce_pkg::t_plan   plan;
    tce_pkg::t_result res_in, res_out;
    logic             plan_valid, plan_pop, clearing, res_push, res_full;

    tce_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_op             (i_op),
        .i_char_code      (i_char_code),
        .i_cell_attribute (i_cell_attribute),
        .i_col            (i_col),
        .i_row            (i_row),
        .i_col_end        (i_col_end),
        .i_region_top     (i_region_top),
        .i_region_bottom  (i_region_bottom),
        .i_count          (i_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_clearing       (clearing),
        .o_plan_valid     (plan_valid),
        .o_plan           (plan),
        .i_plan_pop       (plan_pop)
    );

    tce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_plan_valid (plan_valid),
        .i_plan       (plan),
        .o_plan_pop   (plan_pop),
        .o_clearing   (clearing),
        .o_res_push   (res_push),
        .o_res        (res_in),
        .i_res_full   (res_full)
    );

    tce_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (res_out)
    );

    // Result fields
    assign o_cursor_col    = res_out.cursor_col;
    assign o_cursor_row    = res_out.cursor_row;
    assign o_hw_cursor_pos = res_out.hw_cursor_pos;
    assign o_cell_data     = res_out.cell_data;

endmodule

[sv/tce_front.sv]
// ---------------------------------------------------------------------------
// tce_front
// Accepts items, tracks the cursor and turns each item into a work list
// held in a two-entry queue for the executor.
// ---------------------------------------------------------------------------
module tce_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [2:0]          i_op,
    input  logic [7:0]          i_char_code,
    input  logic [7:0]          i_cell_attribute,
    input  logic signed [7:0]   i_col,
    input  logic signed [7:0]   i_row,
    input  logic signed [7:0]   i_col_end,
    input  logic signed [7:0]   i_region_top,
    input  logic signed [7:0]   i_region_bottom,
    input  logic signed [7:0]   i_count,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_clearing,
    output logic                o_plan_valid,
    output tce_pkg::t_plan      o_plan,
    input  logic                i_plan_pop
);

    logic [7:0]                 r_color;
    logic [tce_pkg::COL_W-1:0]  r_cur_x, n_cur_x;
    logic [tce_pkg::ROW_W-1:0]  r_cur_y, n_cur_y;
    tce_pkg::t_plan             r_q [2];
    logic                       r_wp, r_rp;
    logic [1:0]                 r_qcnt;
    tce_pkg::t_plan             plan;
    logic                       accept;

    assign o_cfg_ready  = 1'b1;
    assign full         = (r_qcnt == 2'd2) || i_clearing;
    assign accept       = push && !full;
    assign o_plan_valid = (r_qcnt != 2'd0);
    assign o_plan       = r_q[r_rp];

    // Item decode: cursor update and work list
    always_comb begin
        logic signed [9:0] nx, ny, s_col, s_row, s_ce, t, b, h, n, k, c0, ce, hx, span;
        logic [15:0]       blank;
        logic              printable;
        nx        = 10'($unsigned(r_cur_x));
        ny        = 10'($unsigned(r_cur_y));
        s_col     = {{2{i_col[7]}}, i_col};
        s_row     = {{2{i_row[7]}}, i_row};
        s_ce      = {{2{i_col_end[7]}}, i_col_end};
        t         = {{2{i_region_top[7]}}, i_region_top};
        b         = {{2{i_region_bottom[7]}}, i_region_bottom};
        n         = {{2{i_count[7]}}, i_count};
        h         = '0;
        k         = '0;
        c0        = '0;
        ce        = '0;
        span      = '0;
        blank     = {r_color, tce_pkg::CHAR_SPACE};
        printable = 1'b0;
        plan      = '0;
        unique case (tce_pkg::t_op'(i_op))
            tce_pkg::OP_PUT: begin
                if (i_char_code == tce_pkg::CHAR_NL) begin
                    nx = '0;
                    ny = ny + 10'sd1;
                end else if (i_char_code == tce_pkg::CHAR_CR) begin
                    nx = '0;
                end else if (i_char_code == tce_pkg::CHAR_BS) begin
                    if (nx > 10'sd0) begin
                        nx           = nx - 10'sd1;
                        plan.pk_en   = 1'b1;
                        plan.pk_val  = blank;
                    end
                end else if (i_char_code == tce_pkg::CHAR_TAB) begin
                    nx = (nx + 10'sd8) & ~10'sd7;
                    if (nx >= tce_pkg::COLS_S) begin
                        nx = '0;
                        ny = ny + 10'sd1;
                    end
                end else if (i_char_code >= tce_pkg::CHAR_SPACE) begin
                    if (nx >= tce_pkg::COLS_S) begin
                        nx = '0;
                        ny = ny + 10'sd1;
                    end
                    printable   = 1'b1;
                    plan.pk_en  = 1'b1;
                    plan.pk_val = {r_color, i_char_code};
                end
                // cursor ran off the bottom: whole screen up one row
                if (ny >= tce_pkg::ROWS_S) begin
                    ny            = tce_pkg::ROWS_S - 10'sd1;
                    plan.cp_en    = 1'b1;
                    plan.cp_src   = tce_pkg::cell_addr(10'sd0, 10'sd1);
                    plan.cp_dst   = '0;
                    plan.cp_len   = tce_pkg::row_len(tce_pkg::ROWS_S - 10'sd1);
                    plan.fl_en    = 1'b1;
                    plan.fl_start = tce_pkg::cell_addr(10'sd0, tce_pkg::ROWS_S - 10'sd1);
                    plan.fl_len   = tce_pkg::row_len(10'sd1);
                    plan.fl_val   = blank;
                end
                plan.pk_addr = tce_pkg::cell_addr(nx, ny);
                if (printable) begin
                    nx = nx + 10'sd1;
                end
            end
            tce_pkg::OP_CLEAR: begin
                nx            = '0;
                ny            = '0;
                plan.fl_en    = 1'b1;
                plan.fl_start = '0;
                plan.fl_len   = tce_pkg::CNT_W'(tce_pkg::CELLS);
                plan.fl_val   = blank;
            end
            tce_pkg::OP_SET_CURSOR: begin
                nx = (s_col < 10'sd0) ? 10'sd0 :
                     (s_col > tce_pkg::COLS_S - 10'sd1) ? tce_pkg::COLS_S - 10'sd1 : s_col;
                ny = (s_row < 10'sd0) ? 10'sd0 :
                     (s_row > tce_pkg::ROWS_S - 10'sd1) ? tce_pkg::ROWS_S - 10'sd1 : s_row;
            end
            tce_pkg::OP_ERASE: begin
                c0 = (s_col < 10'sd0) ? 10'sd0 : s_col;
                ce = (s_ce > tce_pkg::COLS_S) ? tce_pkg::COLS_S : s_ce;
                if (s_row >= 10'sd0 && s_row < tce_pkg::ROWS_S && c0 < ce) begin
                    plan.fl_en    = 1'b1;
                    plan.fl_start = tce_pkg::cell_addr(c0, s_row);
                    plan.fl_len   = tce_pkg::cell_len(ce - c0);
                    plan.fl_val   = blank;
                end
            end
            tce_pkg::OP_SCROLL: begin
                if (t < 10'sd0) t = '0;
                if (b > tce_pkg::ROWS_S - 10'sd1) b = tce_pkg::ROWS_S - 10'sd1;
                if (t <= b && n != 10'sd0) begin
                    h = b - t + 10'sd1;
                    if (n > h) n = h;
                    if (n < -h) n = -h;
                    plan.fl_en  = 1'b1;
                    plan.fl_val = blank;
                    if (n > 10'sd0) begin
                        plan.cp_en    = (h != n);
                        plan.cp_src   = tce_pkg::cell_addr(10'sd0, t + n);
                        plan.cp_dst   = tce_pkg::cell_addr(10'sd0, t);
                        plan.cp_len   = tce_pkg::row_len(h - n);
                        plan.fl_start = tce_pkg::cell_addr(10'sd0, b - n + 10'sd1);
                        plan.fl_len   = tce_pkg::row_len(n);
                    end else begin
                        k             = -n;
                        plan.cp_en    = (h != k);
                        plan.cp_down  = 1'b1;
                        plan.cp_src   = tce_pkg::cell_addr(-10'sd1, b + 10'sd1 - k);
                        plan.cp_dst   = tce_pkg::cell_addr(-10'sd1, b + 10'sd1);
                        plan.cp_len   = tce_pkg::row_len(h - k);
                        plan.fl_start = tce_pkg::cell_addr(10'sd0, t);
                        plan.fl_len   = tce_pkg::row_len(k);
                    end
                end
            end
            tce_pkg::OP_SHIFT: begin
                if (s_row >= 10'sd0 && s_row < tce_pkg::ROWS_S && s_col >= 10'sd0 &&
                    s_col < tce_pkg::COLS_S && n != 10'sd0) begin
                    span = tce_pkg::COLS_S - s_col;
                    k    = (n > 10'sd0) ? n : -n;
                    if (k > span) k = span;
                    plan.cp_en  = (span != k);
                    plan.cp_len = tce_pkg::cell_len(span - k);
                    plan.fl_en  = 1'b1;
                    plan.fl_len = tce_pkg::cell_len(k);
                    plan.fl_val = blank;
                    if (n > 10'sd0) begin
                        plan.cp_down  = 1'b1;
                        plan.cp_src   = tce_pkg::cell_addr(tce_pkg::COLS_S - k - 10'sd1, s_row);
                        plan.cp_dst   = tce_pkg::cell_addr(tce_pkg::COLS_S - 10'sd1, s_row);
                        plan.fl_start = tce_pkg::cell_addr(s_col, s_row);
                    end else begin
                        plan.cp_src   = tce_pkg::cell_addr(s_col + k, s_row);
                        plan.cp_dst   = tce_pkg::cell_addr(s_col, s_row);
                        plan.fl_start = tce_pkg::cell_addr(tce_pkg::COLS_S - k, s_row);
                    end
                end
            end
            tce_pkg::OP_WRITE: begin
                if (s_row >= 10'sd0 && s_row < tce_pkg::ROWS_S && s_col >= 10'sd0 &&
                    s_col < tce_pkg::COLS_S) begin
                    plan.pk_en   = 1'b1;
                    plan.pk_addr = tce_pkg::cell_addr(s_col, s_row);
                    plan.pk_val  = {i_cell_attribute, i_char_code};
                end
            end
            default: begin
                if (s_row >= 10'sd0 && s_row < tce_pkg::ROWS_S && s_col >= 10'sd0 &&
                    s_col < tce_pkg::COLS_S) begin
                    plan.rd_en   = 1'b1;
                    plan.rd_addr = tce_pkg::cell_addr(s_col, s_row);
                end
            end
        endcase
        // cursor report
        hx           = (nx >= tce_pkg::COLS_S) ? tce_pkg::COLS_S - 10'sd1 : nx;
        plan.cur_col = 7'(nx);
        plan.cur_row = 5'(ny);
        plan.hw_pos  = 11'(int'(ny) * tce_pkg::COLS + int'(hx));
        n_cur_x      = tce_pkg::COL_W'(nx);
        n_cur_y      = tce_pkg::ROW_W'(ny);
    end

    // Control registers: color, cursor, queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= tce_pkg::RESET_COLOR;
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_qcnt  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_color <= i_cfg_data;
            end
            if (accept) begin
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
                r_wp    <= !r_wp;
            end
            if (i_plan_pop && o_plan_valid) begin
                r_rp <= !r_rp;
            end
            r_qcnt <= r_qcnt + 2'(accept) - 2'(i_plan_pop && o_plan_valid);
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= plan;
        end
    end

endmodule

[sv/tce_back.sv]
// ---------------------------------------------------------------------------
// tce_back
// Executes work lists against the screen store: block copy, block fill,
// single cell write and cell read, then posts the result item; blanks the store after reset.
// ---------------------------------------------------------------------------
`include "text_console_engine_defines.svh"

module tce_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_plan_valid,
    input  tce_pkg::t_plan  i_plan,
    output logic            o_plan_pop,
    output logic            o_clearing,
    output logic            o_res_push,
    output tce_pkg::t_result o_res,
    input  logic            i_res_full
);

    tce_pkg::t_state             r_state, n_state;
    tce_pkg::t_plan              r_plan;
    logic [tce_pkg::ADDR_W-1:0]  r_src, r_dst, r_faddr;
    logic [tce_pkg::CNT_W-1:0]   r_cnt, r_fcnt;
    logic [15:0]                 r_mem [tce_pkg::CELLS];
    logic [15:0]                 r_rdata;
    logic                        mem_we;
    logic [tce_pkg::ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [15:0]                 mem_wdata;
    tce_pkg::t_state             after_copy, after_fill, after_poke, first_phase;

    // Phase order: copy, fill, write, read
    always_comb begin
        after_poke  = r_plan.rd_en ? tce_pkg::S_READ : tce_pkg::S_DONE;
        after_fill  = r_plan.pk_en ? tce_pkg::S_POKE : after_poke;
        after_copy  = r_plan.fl_en ? tce_pkg::S_FILL : after_fill;
        first_phase = i_plan.cp_en ? tce_pkg::S_COPY_RD :
                      i_plan.fl_en ? tce_pkg::S_FILL :
                      i_plan.pk_en ? tce_pkg::S_POKE :
                      i_plan.rd_en ? tce_pkg::S_READ : tce_pkg::S_DONE;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tce_pkg::S_CLEAR: begin
                if (r_faddr == tce_pkg::ADDR_W'(tce_pkg::CELLS - 1)) n_state = tce_pkg::S_IDLE;
            end
            tce_pkg::S_IDLE: begin
                if (i_plan_valid) n_state = first_phase;
            end
            tce_pkg::S_COPY_RD: n_state = tce_pkg::S_COPY_WR;
            tce_pkg::S_COPY_WR: begin
                n_state = (r_cnt == tce_pkg::CNT_W'(1)) ? after_copy : tce_pkg::S_COPY_RD;
            end
            tce_pkg::S_FILL: begin
                if (r_fcnt == tce_pkg::CNT_W'(1)) n_state = after_fill;
            end
            tce_pkg::S_POKE: n_state = after_poke;
            tce_pkg::S_READ: n_state = tce_pkg::S_DONE;
            tce_pkg::S_DONE: begin
                if (!i_res_full) n_state = tce_pkg::S_IDLE;
            end
            default: n_state = tce_pkg::S_IDLE;
        endcase
    end

    // Outputs and memory port control
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = r_faddr;
        mem_wdata  = r_plan.fl_val;
        mem_raddr  = r_plan.rd_addr;
        o_plan_pop = 1'b0;
        o_res_push = 1'b0;
        o_clearing = (r_state == tce_pkg::S_CLEAR);
        unique case (r_state)
            tce_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = tce_pkg::RESET_BLANK;
            end
            tce_pkg::S_IDLE:    o_plan_pop = i_plan_valid;
            tce_pkg::S_COPY_RD: mem_raddr = r_src;
            tce_pkg::S_COPY_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_dst;
                mem_wdata = r_rdata;
            end
            tce_pkg::S_FILL:    mem_we = 1'b1;
            tce_pkg::S_POKE: begin
                mem_we    = 1'b1;
                mem_waddr = r_plan.pk_addr;
                mem_wdata = r_plan.pk_val;
            end
            tce_pkg::S_READ:    ;
            tce_pkg::S_DONE:    o_res_push = !i_res_full;
            default:            ;
        endcase
        o_res.cursor_col    = r_plan.cur_col;
        o_res.cursor_row    = r_plan.cur_row;
        o_res.hw_cursor_pos = r_plan.hw_pos;
        o_res.cell_data     = r_plan.rd_en ? r_rdata : 16'h0000;
    end

    // State, address and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tce_pkg::S_CLEAR;
            r_faddr <= '0;
            r_fcnt  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                tce_pkg::S_CLEAR: r_faddr <= r_faddr + tce_pkg::ADDR_W'(1);
                tce_pkg::S_IDLE: begin
                    if (i_plan_valid) begin
                        r_cnt   <= i_plan.cp_len;
                        r_fcnt  <= i_plan.fl_len;
                        r_faddr <= i_plan.fl_start;
                    end
                end
                tce_pkg::S_COPY_WR: r_cnt <= r_cnt - tce_pkg::CNT_W'(1);
                tce_pkg::S_FILL: begin
                    r_faddr <= r_faddr + tce_pkg::ADDR_W'(1);
                    r_fcnt  <= r_fcnt - tce_pkg::CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Work list and copy pointers
    always_ff @(posedge i_clk) begin
        if (r_state == tce_pkg::S_IDLE && i_plan_valid) begin
            r_plan <= i_plan;
            r_src  <= i_plan.cp_src;
            r_dst  <= i_plan.cp_dst;
        end else if (r_state == tce_pkg::S_COPY_WR) begin
            r_src <= r_plan.cp_down ? r_src - tce_pkg::ADDR_W'(1) : r_src + tce_pkg::ADDR_W'(1);
            r_dst <= r_plan.cp_down ? r_dst - tce_pkg::ADDR_W'(1) : r_dst + tce_pkg::ADDR_W'(1);
        end
    end

    // Screen store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    `TCE_ASSERT(a_copy_cnt, (r_state != tce_pkg::S_COPY_RD && r_state != tce_pkg::S_COPY_WR) || r_cnt != '0, "copy with zero count")
    `TCE_ASSERT(a_fill_cnt, r_state != tce_pkg::S_FILL || r_fcnt != '0, "fill with zero count")
    `TCE_ASSERT(a_waddr, !mem_we || mem_waddr <= tce_pkg::ADDR_W'(tce_pkg::CELLS - 1), "write past store")
    `TCE_ASSERT_NEXT(a_pop_idle, o_plan_pop, r_state != tce_pkg::S_IDLE && r_state != tce_pkg::S_CLEAR, "pop did not start work")

endmodule

[sv/tce_out.sv]
// ---------------------------------------------------------------------------
// tce_out
// Two-entry result queue between the executor and the result port.
// ---------------------------------------------------------------------------
module tce_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tce_pkg::t_result i_res,
    output logic             o_full,
    output logic             empty,
    input  logic             pop,
    output tce_pkg::t_result o_res
);

    tce_pkg::t_result r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign empty   = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = pop && !empty;
    assign o_res   = r_q[r_rp];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Regression bench for text_console_engine: directed command table, then
// random command streams under several text colors, each result checked
// against an in-bench model of the screen store and cursor or a typed expectation.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int RAND_ITEMS  = 150;

    typedef struct {
        tce_pkg::t_op      op;
        logic [7:0]        ch;
        logic [7:0]        attr;
        logic signed [7:0] col;
        logic signed [7:0] row;
        logic signed [7:0] col_end;
        logic signed [7:0] top;
        logic signed [7:0] bot;
        logic signed [7:0] cnt;
    } t_cmd;

    typedef struct {
        t_cmd             cmd;
        bit               fixed;
        tce_pkg::t_result res;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic [2:0]        i_op;
    logic [7:0]        i_char_code;
    logic [7:0]        i_cell_attribute;
    logic signed [7:0] i_col;
    logic signed [7:0] i_row;
    logic signed [7:0] i_col_end;
    logic signed [7:0] i_region_top;
    logic signed [7:0] i_region_bottom;
    logic signed [7:0] i_count;
    logic              empty;
    logic              pop;
    logic [6:0]        o_cursor_col;
    logic [4:0]        o_cursor_row;
    logic [10:0]       o_hw_cursor_pos;
    logic [15:0]       o_cell_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [7:0]        i_cfg_data;

    text_console_engine dut (.*);

    // Model state
    logic [15:0] scr [0:tce_pkg::CELLS-1];
    int          cur_x;
    int          cur_y;
    logic [7:0]  color;

    tce_pkg::t_result pending_results[$];
    int               mismatches;
    int               cycles;
    bit               calm;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("text_console_engine regression: fail");
            $finish;
        end
    end

    // Blank n cells starting at first
    function automatic void blank_cells(int first, int n);
        for (int i = 0; i < n; i++) scr[first + i] = {color, tce_pkg::CHAR_SPACE};
    endfunction

    // Scroll rows top..bot by n, positive is up
    function automatic void scroll_model(int top, int bot, int n);
        int h;
        if (top < 0) top = 0;
        if (bot > tce_pkg::ROWS - 1) bot = tce_pkg::ROWS - 1;
        if (top > bot || n == 0) return;
        h = bot - top + 1;
        if (n > h) n = h;
        if (n < -h) n = -h;
        if (n > 0) begin
            for (int i = 0; i < (h - n) * tce_pkg::COLS; i++)
                scr[top * tce_pkg::COLS + i] = scr[(top + n) * tce_pkg::COLS + i];
            blank_cells((bot - n + 1) * tce_pkg::COLS, n * tce_pkg::COLS);
        end else begin
            for (int i = (h + n) * tce_pkg::COLS - 1; i >= 0; i--)
                scr[(top - n) * tce_pkg::COLS + i] = scr[top * tce_pkg::COLS + i];
            blank_cells(top * tce_pkg::COLS, -n * tce_pkg::COLS);
        end
    endfunction

    function automatic void wrap_model();
        if (cur_y < tce_pkg::ROWS) return;
        scroll_model(0, tce_pkg::ROWS - 1, 1);
        cur_y = tce_pkg::ROWS - 1;
    endfunction

    function automatic void put_model(logic [7:0] c);
        if (c == tce_pkg::CHAR_NL) begin
            cur_x = 0;
            cur_y++;
        end else if (c == tce_pkg::CHAR_CR) begin
            cur_x = 0;
        end else if (c == tce_pkg::CHAR_BS) begin
            if (cur_x > 0) begin
                cur_x--;
                scr[cur_y * tce_pkg::COLS + cur_x] = {color, tce_pkg::CHAR_SPACE};
            end
        end else if (c == tce_pkg::CHAR_TAB) begin
            cur_x = (cur_x + 8) & ~7;
            if (cur_x >= tce_pkg::COLS) begin
                cur_x = 0;
                cur_y++;
            end
        end else if (c >= tce_pkg::CHAR_SPACE) begin
            // deferred wrap
            if (cur_x >= tce_pkg::COLS) begin
                cur_x = 0;
                cur_y++;
                wrap_model();
            end
            scr[cur_y * tce_pkg::COLS + cur_x] = {color, c};
            cur_x++;
        end
        wrap_model();
    endfunction

    function automatic void shift_model(int x, int y, int n);
        int base, span, k;
        if (y < 0 || y >= tce_pkg::ROWS || x < 0 || x >= tce_pkg::COLS || n == 0) return;
        base = y * tce_pkg::COLS;
        span = tce_pkg::COLS - x;
        k = n > 0 ? n : -n;
        if (k > span) k = span;
        if (n > 0) begin
            for (int i = span - k - 1; i >= 0; i--) scr[base + x + k + i] = scr[base + x + i];
            blank_cells(base + x, k);
        end else begin
            for (int i = 0; i < span - k; i++) scr[base + x + i] = scr[base + x + k + i];
            blank_cells(base + tce_pkg::COLS - k, k);
        end
    endfunction

    // Apply one command, return the console status it produces
    function automatic tce_pkg::t_result console_step(t_cmd c);
        int x, y, e;
        logic [15:0] data;
        tce_pkg::t_result r;
        x = int'(c.col);
        y = int'(c.row);
        e = int'(c.col_end);
        data = '0;
        case (c.op)
            tce_pkg::OP_PUT: put_model(c.ch);
            tce_pkg::OP_CLEAR: begin
                blank_cells(0, tce_pkg::CELLS);
                cur_x = 0;
                cur_y = 0;
            end
            tce_pkg::OP_SET_CURSOR: begin
                cur_x = x < 0 ? 0 : (x > tce_pkg::COLS - 1 ? tce_pkg::COLS - 1 : x);
                cur_y = y < 0 ? 0 : (y > tce_pkg::ROWS - 1 ? tce_pkg::ROWS - 1 : y);
            end
            tce_pkg::OP_ERASE: begin
                if (x < 0) x = 0;
                if (e > tce_pkg::COLS) e = tce_pkg::COLS;
                if (y >= 0 && y < tce_pkg::ROWS && x < e)
                    blank_cells(y * tce_pkg::COLS + x, e - x);
            end
            tce_pkg::OP_SCROLL: scroll_model(int'(c.top), int'(c.bot), int'(c.cnt));
            tce_pkg::OP_SHIFT: shift_model(x, y, int'(c.cnt));
            tce_pkg::OP_WRITE: begin
                if (x >= 0 && y >= 0 && x < tce_pkg::COLS && y < tce_pkg::ROWS)
                    scr[y * tce_pkg::COLS + x] = {c.attr, c.ch};
            end
            default: begin
                if (x >= 0 && y >= 0 && x < tce_pkg::COLS && y < tce_pkg::ROWS)
                    data = scr[y * tce_pkg::COLS + x];
            end
        endcase
        r.cursor_col    = 7'(cur_x);
        r.cursor_row    = 5'(cur_y);
        r.hw_cursor_pos = 11'(cur_y * tce_pkg::COLS +
                              (cur_x >= tce_pkg::COLS ? tce_pkg::COLS - 1 : cur_x));
        r.cell_data     = data;
        return r;
    endfunction

    // Result side: random pop, check against oldest expectation
    always @(negedge i_clk) begin
        pop = calm ? 1'b1 : ($urandom_range(0, 99) >= 15);
    end

    always @(posedge i_clk) begin
        tce_pkg::t_result got, want;
        if (i_rst_n && pop && !empty) begin
            got = '{o_cursor_col, o_cursor_row, o_hw_cursor_pos, o_cell_data};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got.cursor_col != want.cursor_col || got.cursor_row != want.cursor_row
                    || got.hw_cursor_pos != want.hw_cursor_pos
                    || got.cell_data != want.cell_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: col %0d/%0d row %0d/%0d hw %0d/%0d data %h/%h",
                                 want.cursor_col, got.cursor_col, want.cursor_row,
                                 got.cursor_row, want.hw_cursor_pos, got.hw_cursor_pos,
                                 want.cell_data, got.cell_data);
                end
            end
        end
    end

    // Send one command item; typed expectation overrides the model's if given
    task automatic send_cmd(t_cmd c, bit fixed, tce_pkg::t_result fixed_res);
        tce_pkg::t_result r;
        while (!calm && $urandom_range(0, 99) < 15) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push             = 1'b1;
        i_op             = c.op;
        i_char_code      = c.ch;
        i_cell_attribute = c.attr;
        i_col            = c.col;
        i_row            = c.row;
        i_col_end        = c.col_end;
        i_region_top     = c.top;
        i_region_bottom  = c.bot;
        i_count          = c.cnt;
        do @(posedge i_clk); while (full);
        r = console_step(c);
        pending_results.push_back(fixed ? fixed_res : r);
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic write_color(logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        color = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Coordinate: mostly on screen, sometimes any byte
    function automatic logic signed [7:0] pick_coord(int lim);
        return ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, lim - 1)) : 8'($urandom);
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   sel;
        int   k;
        sel       = $urandom_range(0, 99);
        c.ch      = 8'($urandom);
        c.attr    = 8'($urandom);
        c.col     = pick_coord(tce_pkg::COLS);
        c.row     = pick_coord(tce_pkg::ROWS);
        c.col_end = pick_coord(tce_pkg::COLS + 1);
        c.top     = pick_coord(tce_pkg::ROWS);
        c.bot     = pick_coord(tce_pkg::ROWS);
        c.cnt     = ($urandom_range(0, 99) < 75) ? 8'(int'($urandom_range(0, 8)) - 4)
                                                 : 8'($urandom);
        if (sel < 50) begin
            c.op = tce_pkg::OP_PUT;
            k = $urandom_range(0, 7);
            if (k == 0) c.ch = tce_pkg::CHAR_NL;
            else if (k == 1) c.ch = tce_pkg::CHAR_CR;
            else if (k == 2) c.ch = tce_pkg::CHAR_BS;
            else if (k == 3) c.ch = tce_pkg::CHAR_TAB;
            else if (k < 7) c.ch = 8'($urandom_range(32, 255));
        end else if (sel < 51) c.op = tce_pkg::OP_CLEAR;
        else if (sel < 58) c.op = tce_pkg::OP_SET_CURSOR;
        else if (sel < 64) c.op = tce_pkg::OP_ERASE;
        else if (sel < 69) c.op = tce_pkg::OP_SCROLL;
        else if (sel < 75) c.op = tce_pkg::OP_SHIFT;
        else if (sel < 85) c.op = tce_pkg::OP_WRITE;
        else c.op = tce_pkg::OP_READ;
        return c;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            calm = (i >= n / 2 && i < n / 2 + 40);
            send_cmd(random_cmd(), 1'b0, '0);
        end
        calm = 1'b0;
    endtask

    // Directed table
    function automatic t_row mk(tce_pkg::t_op op, logic [7:0] ch, logic [7:0] attr,
                                int col, int row, int cend, int top, int bot, int cnt,
                                bit fixed = 0, tce_pkg::t_result res = '0);
        t_row t;
        t.cmd   = '{op, ch, attr, 8'(col), 8'(row), 8'(cend), 8'(top), 8'(bot), 8'(cnt)};
        t.fixed = fixed;
        t.res   = res;
        return t;
    endfunction

    initial begin
        t_row dir[$];
        mismatches       = 0;
        cycles           = 0;
        calm             = 1'b0;
        color            = tce_pkg::RESET_COLOR;
        cur_x            = 0;
        cur_y            = 0;
        for (int i = 0; i < tce_pkg::CELLS; i++) scr[i] = tce_pkg::RESET_BLANK;
        i_rst_n          = 1'b0;
        push             = 1'b0;
        pop              = 1'b0;
        i_op             = tce_pkg::OP_PUT;
        i_char_code      = '0;
        i_cell_attribute = '0;
        i_col            = '0;
        i_row            = '0;
        i_col_end        = '0;
        i_region_top     = '0;
        i_region_bottom  = '0;
        i_count          = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        dir.push_back(mk(tce_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                         {7'd0, 5'd0, 11'd0, tce_pkg::RESET_BLANK}));
        dir.push_back(mk(tce_pkg::OP_SET_CURSOR, 0, 0, -128, -128, 0, 0, 0, 0, 1, '0));
        dir.push_back(mk(tce_pkg::OP_SET_CURSOR, 0, 0, 127, 127, 0, 0, 0, 0, 1,
                         {7'd79, 5'd24, 11'd1999, 16'h0}));
        dir.push_back(mk(tce_pkg::OP_PUT, 8'h41, 0, 0, 0, 0, 0, 0, 0, 1,
                         {7'd80, 5'd24, 11'd1999, 16'h0}));
        dir.push_back(mk(tce_pkg::OP_PUT, 8'hFF, 0, 0, 0, 0, 0, 0, 0));      // wrap and scroll
        dir.push_back(mk(tce_pkg::OP_PUT, tce_pkg::CHAR_NL, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(tce_pkg::OP_PUT, tce_pkg::CHAR_BS, 0, 0, 0, 0, 0, 0, 0)); // column 0
        dir.push_back(mk(tce_pkg::OP_PUT, tce_pkg::CHAR_TAB, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(tce_pkg::OP_PUT, tce_pkg::CHAR_BS, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(tce_pkg::OP_PUT, 8'h01, 0, 0, 0, 0, 0, 0, 0));      // ignored control
        dir.push_back(mk(tce_pkg::OP_PUT, tce_pkg::CHAR_CR, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(tce_pkg::OP_SET_CURSOR, 0, 0, 75, 3, 0, 0, 0, 0));
        dir.push_back(mk(tce_pkg::OP_PUT, tce_pkg::CHAR_TAB, 0, 0, 0, 0, 0, 0, 0)); // past end
        dir.push_back(mk(tce_pkg::OP_PUT, tce_pkg::CHAR_SPACE, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(tce_pkg::OP_WRITE, 8'hFF, 8'hFF, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(tce_pkg::OP_WRITE, 8'h00, 8'h00, 79, 24, 0, 0, 0, 0));
        dir.push_back(mk(tce_pkg::OP_WRITE, 8'h55, 8'hAA, -1, 127, 0, 0, 0, 0));
        dir.push_back(mk(tce_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(tce_pkg::OP_READ, 0, 0, 127, -128, 0, 0, 0, 0));
        dir.push_back(mk(tce_pkg::OP_ERASE, 0, 0, -128, 0, 127, 0, 0, 0));
        dir.push_back(mk(tce_pkg::OP_ERASE, 0, 0, 10, -1, 20, 0, 0, 0));     // row off screen
        dir.push_back(mk(tce_pkg::OP_ERASE, 0, 0, 30, 5, 30, 0, 0, 0));      // empty span
        dir.push_back(mk(tce_pkg::OP_SCROLL, 0, 0, 0, 0, 0, -128, 127, 1));
        dir.push_back(mk(tce_pkg::OP_SCROLL, 0, 0, 0, 0, 0, 20, 24, -128));
        dir.push_back(mk(tce_pkg::OP_SCROLL, 0, 0, 0, 0, 0, 9, 3, 2));       // top below bottom
        dir.push_back(mk(tce_pkg::OP_SCROLL, 0, 0, 0, 0, 0, 0, 24, 0));
        dir.push_back(mk(tce_pkg::OP_SHIFT, 0, 0, 0, 24, 0, 0, 0, 127));
        dir.push_back(mk(tce_pkg::OP_SHIFT, 0, 0, 40, 24, 0, 0, 0, -128));
        dir.push_back(mk(tce_pkg::OP_SHIFT, 0, 0, 80, 0, 0, 0, 0, 3));       // off screen
        dir.push_back(mk(tce_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1, '0));
        foreach (dir[i]) send_cmd(dir[i].cmd, dir[i].fixed, dir[i].res);

        // Random phases under different colors
        drain();
        write_color(8'hFF);
        random_phase(RAND_ITEMS);
        drain();
        write_color(8'h00);
        random_phase(RAND_ITEMS);
        drain();
        write_color(8'($urandom));
        random_phase(RAND_ITEMS);

        drain();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("text_console_engine regression: pass");
        else
            $display("text_console_engine regression: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/tce_pkg.sv
sv/tce_front.sv
sv/tce_back.sv
sv/tce_out.sv
sv/text_console_engine.sv
tb/tb.sv
